// ===== rtl/fft_radix2_q15_assert.svh =====
// Assertion macros for the radix-2 FFT block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FFT_RADIX2_Q15_ASSERT_SVH
`define FFT_RADIX2_Q15_ASSERT_SVH

// Same-cycle implication, reset masked
`define FFTR2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked
`define FFTR2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fftr2_pkg.sv =====
// Shared types and codes for the radix-2 Q15 FFT.
// No dependencies.
`timescale 1ns / 1ps
package fftr2_pkg;

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    q15_t re;
    q15_t im;
  } cplx_t;

  // operands handed to the butterfly unit
  typedef struct packed {
    cplx_t u;
    cplx_t v;
    q15_t  c;
    q15_t  s;
  } bfly_in_t;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_BIN = 1'b1;

  localparam logic [3:0] LOG2_POINTS_RST = 4'd10;

endpackage

// ===== rtl/fftr2_if.sv =====
// Valid/ready channel interfaces for the FFT command and result streams.
// No dependencies.
`timescale 1ns / 1ps
interface fftr2_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [9:0]         index;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;

  modport source (output valid, operation, index, sample_real, sample_imag, input ready);
  modport sink   (input valid, operation, index, sample_real, sample_imag, output ready);
endinterface

interface fftr2_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] bin_real;
  logic signed [15:0] bin_imag;

  modport source (output valid, kind, bin_real, bin_imag, input ready);
  modport sink   (input valid, kind, bin_real, bin_imag, output ready);
endinterface

// ===== rtl/fftr2_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module fftr2_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fftr2_twid_rom.sv =====
// Twiddle ROM: cos and sin of 2*pi*m/T in Q15, registered read.
// Depends on fftr2_pkg.
`timescale 1ns / 1ps
module fftr2_twid_rom import fftr2_pkg::*; #(
  parameter int T = 1024
) (
  input  logic                  clk,
  input  logic [$clog2(T)-1:0]  addr,
  output q15_t                  cos_o,
  output q15_t                  sin_o
);

  localparam int  TW       = $clog2(T);
  localparam int  TD       = 1 << TW;
  localparam real ANG_STEP = 2.0 * 3.14159265358979323846 / real'(T);

  typedef logic [31:0] rom_t [TD];

  // round magnitude to nearest, saturate +1.0, then restore sign
  function automatic logic [15:0] to_q15(real v);
    real a;
    int  q;
    a = (v < 0.0) ? -v : v;
    q = $rtoi(a * 32768.0 + 0.5);
    if (q > 32767) q = 32767;
    if (v < 0.0) q = -q;
    return 16'(q);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    real  ang;
    for (int m = 0; m < TD; m++) begin
      if (m < T) begin
        ang  = ANG_STEP * real'(m);
        r[m] = {to_q15($cos(ang)), to_q15($sin(ang))};
      end else begin
        r[m] = '0;
      end
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [31:0] q_r;

  always_ff @(posedge clk) begin
    q_r <= ROM[addr];
  end

  assign cos_o = q_r[31:16];
  assign sin_o = q_r[15:0];

endmodule

// ===== rtl/fftr2_bfly.sv =====
// Scaled radix-2 butterfly: halves both operands, products registered,
// wrapping 16-bit sums after. Depends on fftr2_pkg.
`timescale 1ns / 1ps
module fftr2_bfly import fftr2_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  bfly_in_t op_i,
  output cplx_t    a_o,
  output cplx_t    b_o
);

  q15_t               vr, vi;
  q15_t               ur_r, ui_r;
  logic signed [31:0] p_vr_c_r, p_vi_s_r, p_vi_c_r, p_vr_s_r;
  q15_t               twr, twi;

  // operands halved by arithmetic shift
  assign vr = op_i.v.re >>> 1;
  assign vi = op_i.v.im >>> 1;

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      ur_r     <= op_i.u.re >>> 1;
      ui_r     <= op_i.u.im >>> 1;
      p_vr_c_r <= vr * op_i.c;
      p_vi_s_r <= vi * op_i.s;
      p_vi_c_r <= vi * op_i.c;
      p_vr_s_r <= vr * op_i.s;
    end
  end

  // >>15 then wrap: only bits 30..15 survive
  assign twr = p_vr_c_r[30:15] + p_vi_s_r[30:15];
  assign twi = p_vi_c_r[30:15] - p_vr_s_r[30:15];

  assign a_o.re = ur_r + twr;
  assign a_o.im = ui_r + twi;
  assign b_o.re = ur_r - twr;
  assign b_o.im = ui_r - twi;

endmodule

// ===== rtl/fft_radix2_q15.sv =====
// In-place radix-2 decimation-in-time FFT on Q15 complex samples, scaled by 1/N.
// A load returns nothing; a read fetches in state S_RD, and its bin transfer then
// stands valid from the registered output. A run permutes the samples into
// bit-reversed order, one swap at a time through the single write port of the
// sample RAM, then passes every butterfly through the one butterfly unit and ends
// with an acknowledgement. No new item is taken while a result waits to be taken.
// Needs fftr2_pkg, fftr2_if, fftr2_ram, fftr2_twid_rom, fftr2_bfly.
`timescale 1ns / 1ps
module fft_radix2_q15 import fftr2_pkg::*; #(
  parameter int MAX_POINTS         = 1024,
  parameter int TWIDDLE_TABLE_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  fftr2_in_if.sink           in_ch,
  fftr2_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data
);

`include "fft_radix2_q15_assert.svh"

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int MAXLOG = $clog2(MAX_POINTS + 1) - 1;
  localparam int TW     = $clog2(TWIDDLE_TABLE_SIZE);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ACK,
    S_BR_CHK, S_BR_RB, S_BR_WR, S_BR_WI,
    S_BF_RA, S_BF_RB, S_BF_MUL, S_BF_WA, S_BF_WB
  } state_t;

  state_t          state_r, state_nxt;
  logic [3:0]      cfg_r, cfg_nxt;
  logic [3:0]      lg_r, lg_nxt;
  logic [AW:0]     n_r, n_nxt;
  logic [AW:0]     i_r, i_nxt;
  logic [AW-1:0]   rev_r, rev_nxt;
  cplx_t           dtmp_r, dtmp_nxt;
  cplx_t           ua_r, ua_nxt;
  logic [AW:0]     half_r, half_nxt;
  logic [AW:0]     k_r, k_nxt;
  logic [AW:0]     j_r, j_nxt;
  logic [TW-1:0]   m_r, m_nxt;
  logic [TW-1:0]   step_r, step_nxt;
  logic            rd_oob_r, rd_oob_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  q15_t            out_re_r, out_re_nxt;
  q15_t            out_im_r, out_im_nxt;

  logic            in_fire, in_range;
  logic [3:0]      lg_calc;
  logic [AW-1:0]   rev_full, rev_calc;
  logic [AW-1:0]   a_addr, b_addr;
  logic [AW:0]     k_step;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;
  cplx_t           rd_data;
  q15_t            tw_cos, tw_sin;
  logic            bfly_en;
  bfly_in_t        bfly_in;
  cplx_t           bf_a, bf_b;

  // storage and arithmetic units
  fftr2_ram #(.W(32), .D(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fftr2_twid_rom #(.T(TWIDDLE_TABLE_SIZE)) u_twid (
    .clk   (clk),
    .addr  (m_r),
    .cos_o (tw_cos),
    .sin_o (tw_sin)
  );

  fftr2_bfly u_bfly (
    .clk  (clk),
    .en   (bfly_en),
    .op_i (bfly_in),
    .a_o  (bf_a),
    .b_o  (bf_b)
  );

  assign rd_data = cplx_t'(ram_rdata);

  // handshake
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.index) < MAX_POINTS;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.bin_real = out_re_r;
  assign out_ch.bin_imag = out_im_r;

  // transform length clipped to what the store holds
  assign lg_calc = (32'(cfg_r) > MAXLOG) ? 4'(MAXLOG) : cfg_r;

  // bit reversal of i over lg bits
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = i_r[AW-1-b];
    end
  end
  assign rev_calc = rev_full >> (AW - int'(lg_r));

  // butterfly addresses
  assign a_addr = AW'(k_r + j_r);
  assign b_addr = AW'(k_r + j_r + half_r);
  assign k_step = k_r + (half_r << 1);

  assign bfly_in.u = ua_r;
  assign bfly_in.v = rd_data;
  assign bfly_in.c = tw_cos;
  assign bfly_in.s = tw_sin;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    lg_nxt        = lg_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    rev_nxt       = rev_r;
    dtmp_nxt      = dtmp_r;
    ua_nxt        = ua_r;
    half_nxt      = half_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    step_nxt      = step_r;
    rd_oob_nxt    = rd_oob_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    bfly_en       = 1'b0;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      cfg_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            OP_LOAD: begin
              ram_we    = in_range;
              ram_waddr = AW'(in_ch.index);
              ram_wdata = {in_ch.sample_real, in_ch.sample_imag};
            end
            OP_READ: begin
              ram_raddr  = AW'(in_ch.index);
              rd_oob_nxt = !in_range;
              state_nxt  = S_RD;
            end
            OP_RUN: begin
              lg_nxt = lg_calc;
              n_nxt  = (AW+1)'(1) << lg_calc;
              i_nxt  = '0;
              state_nxt = (lg_calc == 4'd0) ? S_ACK : S_BR_CHK;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_BIN;
        out_re_nxt    = rd_oob_r ? '0 : rd_data.re;
        out_im_nxt    = rd_oob_r ? '0 : rd_data.im;
        state_nxt     = S_IDLE;
      end
      S_ACK: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ACK;
        out_re_nxt    = '0;
        out_im_nxt    = '0;
        state_nxt     = S_IDLE;
      end
      // bit-reversal permutation, one index at a time
      S_BR_CHK: begin
        if (i_r == n_r) begin
          half_nxt  = (AW+1)'(1);
          k_nxt     = '0;
          j_nxt     = '0;
          m_nxt     = '0;
          step_nxt  = TW'(TWIDDLE_TABLE_SIZE >> 1);
          state_nxt = S_BF_RA;
        end else if (i_r[AW-1:0] < rev_calc) begin
          ram_raddr = i_r[AW-1:0];
          rev_nxt   = rev_calc;
          state_nxt = S_BR_RB;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_BR_RB: begin
        dtmp_nxt  = rd_data;
        ram_raddr = rev_r;
        state_nxt = S_BR_WR;
      end
      S_BR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_BR_WI;
      end
      S_BR_WI: begin
        ram_we    = 1'b1;
        ram_waddr = rev_r;
        ram_wdata = dtmp_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_BR_CHK;
      end
      // butterflies: read a, read b, multiply, write a, write b
      S_BF_RA: begin
        ram_raddr = a_addr;
        state_nxt = S_BF_RB;
      end
      S_BF_RB: begin
        ua_nxt    = rd_data;
        ram_raddr = b_addr;
        state_nxt = S_BF_MUL;
      end
      S_BF_MUL: begin
        bfly_en   = 1'b1;
        state_nxt = S_BF_WA;
      end
      S_BF_WA: begin
        ram_we    = 1'b1;
        ram_waddr = a_addr;
        ram_wdata = bf_a;
        state_nxt = S_BF_WB;
      end
      S_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_addr;
        ram_wdata = bf_b;
        state_nxt = S_BF_RA;
        if (k_step == n_r) begin
          k_nxt = '0;
          if (j_r + 1'b1 == half_r) begin
            j_nxt = '0;
            m_nxt = '0;
            if ((half_r << 1) == n_r) begin
              state_nxt = S_ACK;
            end else begin
              half_nxt = half_r << 1;
              step_nxt = step_r >> 1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
            m_nxt = TW'(m_r + step_r);
          end
        end else begin
          k_nxt = k_step;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    lg_r       <= lg_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    rev_r      <= rev_nxt;
    dtmp_r     <= dtmp_nxt;
    ua_r       <= ua_nxt;
    half_r     <= half_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    m_r        <= m_nxt;
    step_r     <= step_nxt;
    rd_oob_r   <= rd_oob_nxt;
    out_kind_r <= out_kind_nxt;
    out_re_r   <= out_re_nxt;
    out_im_r   <= out_im_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= LOG2_POINTS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `FFTR2_ASSERT_NXT(a_read_goes_rd, in_fire && in_ch.operation == OP_READ, state_r == S_RD, "read transfer did not fetch")
  `FFTR2_ASSERT_NOW(a_idle_write_is_load, state_r == S_IDLE && ram_we, in_fire && in_ch.operation == OP_LOAD, "store written while idle without load")
  `FFTR2_ASSERT_NOW(a_bfly_order, state_r == S_BF_WB, a_addr < b_addr, "butterfly upper leg not above lower leg")
  `FFTR2_ASSERT_NXT(a_ack_out, state_r == S_ACK, out_valid_r && out_kind_r == KIND_ACK, "run finished without acknowledgement")

endmodule
